// File: src/three_wire_rtc_serial_master_macros.svh
// assertion macros for the three-wire rtc master
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH

// same-cycle implication
`define RTC3W_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtc3w check failed");

// next-cycle implication
`define RTC3W_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtc3w check failed");

`endif

// File: src/tw_rtc_pkg.sv
package tw_rtc_pkg;

  localparam int CMD_W = 3;
  localparam int ADDR_W = 6;
  localparam int BYTE_W = 8;
  localparam int BIDX_W = 3;
  localparam int BUF_DEPTH = 8;
  localparam int BURST_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SINGLE_WR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SINGLE_RD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BURST_WR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BURST_RD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd5;

  localparam logic [1:0] MODE_SW = 2'd0;
  localparam logic [1:0] MODE_SR = 2'd1;
  localparam logic [1:0] MODE_BW = 2'd2;
  localparam logic [1:0] MODE_BR = 2'd3;

  localparam logic [BYTE_W-1:0] CB_SINGLE_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] CB_READ_BIT = 8'h01;
  localparam logic [BYTE_W-1:0] CB_BURST_WR = 8'hBE;
  localparam logic [BYTE_W-1:0] CB_BURST_RD = 8'hBF;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TICK = 2'd0;
  localparam kind_t KIND_START = 2'd1;
  localparam kind_t KIND_LOAD = 2'd2;
  localparam kind_t KIND_NOP = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  typedef struct packed {
    kind_t kind;
    logic [1:0] mode;
    logic [BYTE_W-1:0] cmd_byte;
    logic [BYTE_W-1:0] write_data;
    logic [BIDX_W-1:0] buffer_index;
    logic io_in;
  } q_entry_t;

  typedef struct packed {
    logic chip_enable;
    logic clock_pulse;
    logic io_out;
    logic io_drive;
    logic read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic [BIDX_W-1:0] read_index;
    logic busy_res;
    logic done_res;
    logic start_rejected;
  } res_t;

endpackage

// File: src/tw_rtc_in_if.sv
interface tw_rtc_in_if;
  import tw_rtc_pkg::*;

  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [ADDR_W-1:0] reg_addr;
  logic [BYTE_W-1:0] write_data;
  logic [BIDX_W-1:0] buffer_index;
  logic io_in;

  modport source (
    output valid, command, reg_addr, write_data, buffer_index, io_in,
    input ready
  );
  modport sink (
    input valid, command, reg_addr, write_data, buffer_index, io_in,
    output ready
  );
endinterface

// File: src/tw_rtc_out_if.sv
interface tw_rtc_out_if;
  import tw_rtc_pkg::*;

  logic valid;
  logic ready;
  logic chip_enable;
  logic clock_pulse;
  logic io_out;
  logic io_drive;
  logic read_valid;
  logic [BYTE_W-1:0] read_byte;
  logic [BIDX_W-1:0] read_index;
  logic busy_res;
  logic done_res;
  logic start_rejected;

  modport source (
    output valid, chip_enable, clock_pulse, io_out, io_drive, read_valid, read_byte,
      read_index, busy_res, done_res, start_rejected,
    input ready
  );
  modport sink (
    input valid, chip_enable, clock_pulse, io_out, io_drive, read_valid, read_byte,
      read_index, busy_res, done_res, start_rejected,
    output ready
  );
endinterface

// File: src/tw_rtc_front.sv
module tw_rtc_front (
  input  logic                clk,
  input  logic                rst_n,
  tw_rtc_in_if.sink           in_ch,
  output logic                head_valid,
  output tw_rtc_pkg::q_entry_t head,
  input  logic                pop
);
  import tw_rtc_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t queue_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  q_entry_t entry;
  logic push;

  // classify the incoming item
  always_comb begin
    entry = '0;
    entry.write_data = in_ch.write_data;
    entry.buffer_index = in_ch.buffer_index;
    entry.io_in = in_ch.io_in;
    entry.mode = 2'(in_ch.command - CMD_SINGLE_WR);
    unique case (in_ch.command)
      CMD_TICK: entry.kind = KIND_TICK;
      CMD_SINGLE_WR: begin
        entry.kind = KIND_START;
        entry.cmd_byte = CB_SINGLE_BASE | {1'b0, in_ch.reg_addr, 1'b0};
      end
      CMD_SINGLE_RD: begin
        entry.kind = KIND_START;
        entry.cmd_byte = CB_SINGLE_BASE | CB_READ_BIT | {1'b0, in_ch.reg_addr, 1'b0};
      end
      CMD_BURST_WR: begin
        entry.kind = KIND_START;
        entry.cmd_byte = CB_BURST_WR;
      end
      CMD_BURST_RD: begin
        entry.kind = KIND_START;
        entry.cmd_byte = CB_BURST_RD;
      end
      CMD_LOAD: entry.kind = KIND_LOAD;
      default: entry.kind = KIND_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != QC_W'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign head_valid = (count_r != '0);
  assign head = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// File: src/tw_rtc_back.sv
module tw_rtc_back #(
  parameter int BURST_BYTES = tw_rtc_pkg::BURST_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  tw_rtc_pkg::q_entry_t head,
  output logic                 pop,
  tw_rtc_out_if.source         out_ch
);
  import tw_rtc_pkg::*;

  localparam int BC_W = $clog2(BURST_BYTES + 1);
  localparam int BI_W = $clog2(BUF_DEPTH);

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [BYTE_W-1:0] cmd_shift_r, cmd_shift_nxt;
  logic [BYTE_W-1:0] data_shift_r, data_shift_nxt;
  logic [2:0] bit_count_r, bit_count_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic enable_r, enable_nxt;
  logic [BYTE_W-1:0] single_data_r, single_data_nxt;
  logic [BYTE_W-1:0] burst_buffer_r [BUF_DEPTH];
  logic out_valid_r;
  res_t out_r;

  res_t res;
  logic buf_we;
  logic [BI_W-1:0] rd_idx;
  logic [BYTE_W-1:0] next_byte;
  logic [BYTE_W-1:0] shifted_in;
  logic [BC_W-1:0] byte_inc;
  logic [BC_W-1:0] byte_total;
  logic is_read;

  assign pop = head_valid && (!out_valid_r || out_ch.ready);
  assign is_read = mode_r[0];
  assign byte_inc = byte_count_r + 1'b1;
  assign byte_total = mode_r[1] ? BC_W'(BURST_BYTES) : BC_W'(1);
  assign shifted_in = {head.io_in, data_shift_r[BYTE_W-1:1]};

  // byte to send next: first data byte after the command, or the one after this
  assign rd_idx = (phase_r == PH_CMD) ? '0 : BI_W'(byte_inc);
  always_comb begin
    unique case (mode_r)
      MODE_BW: next_byte = burst_buffer_r[rd_idx];
      MODE_SW: next_byte = single_data_r;
      default: next_byte = '0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt = mode_r;
    cmd_shift_nxt = cmd_shift_r;
    data_shift_nxt = data_shift_r;
    bit_count_nxt = bit_count_r;
    byte_count_nxt = byte_count_r;
    enable_nxt = enable_r;
    single_data_nxt = single_data_r;
    buf_we = 1'b0;
    res = '0;
    res.chip_enable = enable_r;
    res.io_out = 1'b1;
    if (pop) begin
      unique case (head.kind)
        KIND_START: begin
          if (phase_r != PH_IDLE) begin
            res.start_rejected = 1'b1;
          end else begin
            mode_nxt = head.mode;
            cmd_shift_nxt = head.cmd_byte;
            single_data_nxt = head.write_data;
            data_shift_nxt = '0;
            bit_count_nxt = '0;
            byte_count_nxt = '0;
            enable_nxt = 1'b1;
            phase_nxt = PH_CMD;
            res.chip_enable = 1'b1;
          end
        end
        KIND_LOAD: buf_we = 1'b1;
        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            res.clock_pulse = 1'b1;
            bit_count_nxt = bit_count_r + 1'b1;
            if (phase_r == PH_CMD) begin
              res.io_drive = 1'b1;
              res.io_out = cmd_shift_r[0];
              cmd_shift_nxt = cmd_shift_r >> 1;
              if (bit_count_r == 3'd7) begin
                phase_nxt = PH_DATA;
                byte_count_nxt = '0;
                data_shift_nxt = next_byte;
              end
            end else begin
              if (is_read) begin
                data_shift_nxt = shifted_in;
              end else begin
                res.io_drive = 1'b1;
                res.io_out = data_shift_r[0];
                data_shift_nxt = data_shift_r >> 1;
              end
              if (bit_count_r == 3'd7) begin
                if (is_read) begin
                  res.read_valid = 1'b1;
                  res.read_byte = shifted_in;
                  res.read_index = BIDX_W'(byte_count_r);
                end
                if (byte_inc >= byte_total) begin
                  phase_nxt = PH_IDLE;
                  enable_nxt = 1'b0;
                  res.done_res = 1'b1;
                  byte_count_nxt = '0;
                  data_shift_nxt = '0;
                end else begin
                  byte_count_nxt = byte_inc;
                  data_shift_nxt = next_byte;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mode_r <= '0;
      cmd_shift_r <= '0;
      data_shift_r <= '0;
      bit_count_r <= '0;
      byte_count_r <= '0;
      enable_r <= 1'b0;
      single_data_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      mode_r <= mode_nxt;
      cmd_shift_r <= cmd_shift_nxt;
      data_shift_r <= data_shift_nxt;
      bit_count_r <= bit_count_nxt;
      byte_count_r <= byte_count_nxt;
      enable_r <= enable_nxt;
      single_data_r <= single_data_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      burst_buffer_r[head.buffer_index] <= head.write_data;
    end
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.chip_enable = out_r.chip_enable;
  assign out_ch.clock_pulse = out_r.clock_pulse;
  assign out_ch.io_out = out_r.io_out;
  assign out_ch.io_drive = out_r.io_drive;
  assign out_ch.read_valid = out_r.read_valid;
  assign out_ch.read_byte = out_r.read_byte;
  assign out_ch.read_index = out_r.read_index;
  assign out_ch.busy_res = out_r.busy_res;
  assign out_ch.done_res = out_r.done_res;
  assign out_ch.start_rejected = out_r.start_rejected;

endmodule

// File: src/three_wire_rtc_serial_master.sv
// three-wire rtc serial master, lsb first
// in_ch carries one item per transfer: a start command (single or burst,
// read or write), a burst buffer load, or a tick that issues one serial
// clock pulse during a transaction. out_ch returns exactly one result
// per item, in order, with the line levels, the read byte and index
// when a byte completes, and the busy, done and start-rejected flags.
// an accepted item sits in a two-entry queue, the back end executes it in
// the next cycle at the earliest and registers its result.
// throughput is one item per cycle, set by the back end which retires one
// queue entry a cycle while its output register is free or being taken.
// when out_ch stalls the output register holds its result, the queue takes
// up to two more transfers and then in_ch.ready drops.
// reset clears the queue and the transaction state; the burst buffer keeps
// its contents and must be loaded before a burst write uses it.
module three_wire_rtc_serial_master #(
  parameter int BURST_BYTES = tw_rtc_pkg::BURST_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tw_rtc_in_if.sink   in_ch,
  tw_rtc_out_if.source out_ch
);
  import tw_rtc_pkg::*;

  logic head_valid;
  logic pop;
  q_entry_t head;

  tw_rtc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tw_rtc_back #(
    .BURST_BYTES (BURST_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// File: src/tw_rtc_checker.sv
`include "three_wire_rtc_serial_master_macros.svh"

module tw_rtc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic chip_enable,
  input logic clock_pulse,
  input logic io_drive,
  input logic read_valid,
  input logic busy_res,
  input logic done_res
);

  `RTC3W_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(done_res))
  `RTC3W_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res && clock_pulse)
  `RTC3W_ASSERT_NOW(a_read_released, out_valid && read_valid, clock_pulse && !io_drive)
  `RTC3W_ASSERT_NOW(a_pulse_enabled, out_valid && clock_pulse, chip_enable)

endmodule

bind three_wire_rtc_serial_master tw_rtc_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .chip_enable (out_ch.chip_enable),
  .clock_pulse (out_ch.clock_pulse),
  .io_drive    (out_ch.io_drive),
  .read_valid  (out_ch.read_valid),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res)
);
